/* src/scs_pkg.sv */
package scs_pkg;

    localparam logic [7:0] CH_BSLASH = 8'h5C;
    localparam logic [7:0] CH_DQUOTE = 8'h22;
    localparam logic [7:0] CH_SQUOTE = 8'h27;
    localparam logic [7:0] CH_SLASH  = 8'h2F;
    localparam logic [7:0] CH_STAR   = 8'h2A;
    localparam logic [7:0] CH_LF     = 8'h0A;
    localparam logic [7:0] CH_CR     = 8'h0D;
    localparam logic [7:0] CH_SPACE  = 8'h20;

    typedef enum logic [2:0] {
        M_NORMAL,
        M_QUOTE,
        M_ESCAPE,
        M_LINE_OPEN,
        M_LINE,
        M_BLOCK_OPEN,
        M_BLOCK,
        M_BLOCK_CLOSE
    } mode_t;

    typedef struct packed {
        logic [7:0] ch;
        logic       last;
    } result_t;

    // results produced by one accepted item, in order r0 then r1
    typedef struct packed {
        logic    v0;
        logic    v1;
        result_t r0;
        result_t r1;
    } push_t;

    typedef struct packed {
        logic [7:0] ch;
        mode_t      mode;
        logic       quote_single;
    } judge_t;

    // Judge byte b in mode m; n is the lookahead byte, valid when has_next.
    function automatic judge_t judge(mode_t m, logic q, logic [7:0] b,
                                     logic has_next, logic [7:0] n);
        judge_t r;
        logic   eol;
        begin
            r.ch           = b;
            r.mode         = m;
            r.quote_single = q;
            eol            = (b == CH_LF) || (b == CH_CR);
            case (m)
                M_NORMAL:
                begin
                    if (b == CH_DQUOTE || b == CH_SQUOTE)
                    begin
                        r.quote_single = (b == CH_SQUOTE);
                        r.mode         = M_QUOTE;
                    end
                    else if (b == CH_SLASH && has_next && n == CH_SLASH)
                    begin
                        r.mode = M_LINE_OPEN;
                        r.ch   = CH_SPACE;
                    end
                    else if (b == CH_SLASH && has_next && n == CH_STAR)
                    begin
                        r.mode = M_BLOCK_OPEN;
                        r.ch   = CH_SPACE;
                    end
                end
                M_QUOTE:
                begin
                    if (b == CH_BSLASH && has_next)
                        r.mode = M_ESCAPE;
                    else if (b == (q ? CH_SQUOTE : CH_DQUOTE))
                        r.mode = M_NORMAL;
                end
                M_ESCAPE:
                    r.mode = M_QUOTE;
                M_LINE_OPEN:
                begin
                    r.mode = M_LINE;
                    r.ch   = CH_SPACE;
                end
                M_LINE:
                begin
                    if (eol)
                        r.mode = M_NORMAL;
                    else
                        r.ch = CH_SPACE;
                end
                M_BLOCK_OPEN:
                begin
                    r.mode = M_BLOCK;
                    r.ch   = CH_SPACE;
                end
                M_BLOCK:
                begin
                    if (b == CH_STAR && has_next && n == CH_SLASH)
                    begin
                        r.mode = M_BLOCK_CLOSE;
                        r.ch   = CH_SPACE;
                    end
                    else if (!eol)
                        r.ch = CH_SPACE;
                end
                default:
                begin
                    r.mode = M_NORMAL;
                    r.ch   = CH_SPACE;
                end
            endcase
            return r;
        end
    endfunction

endpackage

/* src/scs_judge.sv */
module scs_judge (
    input  logic                 clk,
    input  logic                 rst_n,
    input  logic                 accept,
    input  logic [7:0]           ch,
    input  logic                 last,
    output scs_pkg::push_t       push
);

    scs_pkg::mode_t mode_reg, mode_next;
    logic           quote_reg, quote_next;
    logic           held_valid_reg, held_valid_next;
    logic [7:0]     held_byte_reg, held_byte_next;

    scs_pkg::judge_t j_held;
    scs_pkg::judge_t j_fin;
    scs_pkg::mode_t  mode_mid;
    logic            quote_mid;

    always_comb
    begin
        j_held    = scs_pkg::judge(mode_reg, quote_reg, held_byte_reg, 1'b1, ch);
        mode_mid  = held_valid_reg ? j_held.mode : mode_reg;
        quote_mid = held_valid_reg ? j_held.quote_single : quote_reg;
        // final byte has no lookahead
        j_fin     = scs_pkg::judge(mode_mid, quote_mid, ch, 1'b0, 8'h00);

        push.v0      = accept && (held_valid_reg || last);
        push.v1      = accept && held_valid_reg && last;
        push.r0.ch   = held_valid_reg ? j_held.ch : j_fin.ch;
        push.r0.last = !held_valid_reg;
        push.r1.ch   = j_fin.ch;
        push.r1.last = 1'b1;

        mode_next       = mode_reg;
        quote_next      = quote_reg;
        held_valid_next = held_valid_reg;
        held_byte_next  = held_byte_reg;
        if (accept)
        begin
            if (last)
            begin
                mode_next       = scs_pkg::M_NORMAL;
                quote_next      = 1'b0;
                held_valid_next = 1'b0;
                held_byte_next  = 8'h00;
            end
            else
            begin
                mode_next       = mode_mid;
                quote_next      = quote_mid;
                held_valid_next = 1'b1;
                held_byte_next  = ch;
            end
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            mode_reg       <= scs_pkg::M_NORMAL;
            quote_reg      <= 1'b0;
            held_valid_reg <= 1'b0;
            held_byte_reg  <= 8'h00;
        end
        else
        begin
            mode_reg       <= mode_next;
            quote_reg      <= quote_next;
            held_valid_reg <= held_valid_next;
            held_byte_reg  <= held_byte_next;
        end
    end

endmodule

/* src/scs_outq.sv */
module scs_outq (
    input  logic            clk,
    input  logic            rst_n,
    input  scs_pkg::push_t  push,
    output logic            room,
    output logic            out_valid,
    input  logic            out_ready,
    output logic [7:0]      out_ch,
    output logic            out_last
);

    // three-slot shift queue, head in slot 0
    scs_pkg::result_t ent_reg [0:2];
    scs_pkg::result_t ent_next [0:2];
    logic [1:0]       cnt_reg, cnt_next;
    logic [1:0]       base;
    logic             pop;

    assign out_valid = (cnt_reg != 2'd0);
    assign out_ch    = ent_reg[0].ch;
    assign out_last  = ent_reg[0].last;
    assign room      = (cnt_reg <= 2'd1);
    assign pop       = out_valid && out_ready;

    always_comb
    begin
        ent_next[0] = ent_reg[0];
        ent_next[1] = ent_reg[1];
        ent_next[2] = ent_reg[2];
        base        = cnt_reg;
        if (pop)
        begin
            ent_next[0] = ent_reg[1];
            ent_next[1] = ent_reg[2];
            base        = cnt_reg - 2'd1;
        end
        for (int i = 0; i < 3; i++)
        begin
            if (push.v0 && base == 2'(i))
                ent_next[i] = push.r0;
            if (push.v1 && (base + 2'd1) == 2'(i))
                ent_next[i] = push.r1;
        end
        cnt_next = base + {1'b0, push.v0} + {1'b0, push.v1};
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            cnt_reg <= 2'd0;
        else
            cnt_reg <= cnt_next;
    end

    always_ff @(posedge clk)
    begin
        ent_reg[0] <= ent_next[0];
        ent_reg[1] <= ent_next[1];
        ent_reg[2] <= ent_next[2];
    end

endmodule

/* src/source_comment_stripper.sv */
// Comment stripper for C-style source text.
// Input channel (in_valid/in_ready, ch, last): one source byte per item, last
// marks the final byte of a text. Output channel (out_valid/out_ready, out_ch,
// out_last): the same number of bytes back, comment bytes replaced by spaces,
// CR/LF kept, quoted text (with backslash escapes) left alone.
// Each byte is held until the next one arrives, since a slash or star needs
// one byte of lookahead. A byte's result is therefore queued when the next
// item is accepted and reaches the output through the queue's registered
// head; the final item queues the held byte's result, if any, and its own,
// and returns the block to normal mode for the next text.
// Throughput: one item per cycle, set by the held-byte register feeding the
// two-deep judge logic and the three-slot output queue. A final item with a
// held byte queues two results, so in_ready drops for one cycle after it even
// when the receiver never stalls.
// in_ready depends only on the queue fill (at most one result waiting), so an
// item is still taken while a result waits for the receiver. If the receiver
// stalls the queue fills and in_ready drops until it drains.
// Reset (rst_n low, asynchronous) empties the queue, drops the held byte and
// returns to normal mode.
module source_comment_stripper (
    input  logic       clk,
    input  logic       rst_n,
    input  logic       in_valid,
    output logic       in_ready,
    input  logic [7:0] ch,
    input  logic       last,
    output logic       out_valid,
    input  logic       out_ready,
    output logic [7:0] out_ch,
    output logic       out_last
);

    scs_pkg::push_t push;
    logic           room;
    logic           accept;

    assign in_ready = room;
    assign accept   = in_valid && room;

    // mode tracking, held byte, result generation
    scs_judge u_judge (
        .clk    (clk),
        .rst_n  (rst_n),
        .accept (accept),
        .ch     (ch),
        .last   (last),
        .push   (push)
    );

    // result queue / output register
    scs_outq u_outq (
        .clk       (clk),
        .rst_n     (rst_n),
        .push      (push),
        .room      (room),
        .out_valid (out_valid),
        .out_ready (out_ready),
        .out_ch    (out_ch),
        .out_last  (out_last)
    );

endmodule

/* src/scs_checker.sv */
module scs_checker (
    input logic       clk,
    input logic       rst_n,
    input logic       in_valid,
    input logic       in_ready,
    input logic [7:0] ch,
    input logic       last,
    input logic       out_valid,
    input logic       out_ready,
    input logic [7:0] out_ch,
    input logic       out_last
);

    // stalled result holds
    a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && !out_ready |=> out_valid && $stable(out_ch) && $stable(out_last))
        else $error("output changed under stall");

    // offered item holds until taken
    a_in_hold: assert property (@(posedge clk) disable iff (!rst_n)
        in_valid && !in_ready |=> in_valid && $stable(ch) && $stable(last))
        else $error("input changed before accept");

    // input is only refused while results are pending
    a_stall_cause: assert property (@(posedge clk) disable iff (!rst_n)
        !in_ready |-> out_valid)
        else $error("input refused with empty output");

    // a final item always flushes a result
    a_last_flush: assert property (@(posedge clk) disable iff (!rst_n)
        in_valid && in_ready && last |=> out_valid)
        else $error("final item produced no result");

    // nothing shown during reset
    a_reset_empty: assert property (@(posedge clk)
        !rst_n |-> !out_valid)
        else $error("output valid during reset");

endmodule

bind source_comment_stripper scs_checker u_scs_checker (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_valid  (in_valid),
    .in_ready  (in_ready),
    .ch        (ch),
    .last      (last),
    .out_valid (out_valid),
    .out_ready (out_ready),
    .out_ch    (out_ch),
    .out_last  (out_last)
);

/* tb/stripper_tb_pkg.sv */
package stripper_tb_pkg;

    import scs_pkg::*;

    class strip_scoreboard;
        mode_t      mode;
        bit         quote_single;
        bit         held;
        logic [7:0] held_ch;
        result_t    expected_text[$];
        int         failures;

        function new();
            mode         = M_NORMAL;
            quote_single = 1'b0;
            held         = 1'b0;
            held_ch      = 8'h00;
            failures     = 0;
        endfunction

        // Output byte for b, with lookahead n when has_next; moves the mode on.
        function logic [7:0] blank_byte(logic [7:0] b, bit has_next, logic [7:0] n);
            bit eol;
            bit slash_next;
            bit star_next;
            eol        = (b == CH_LF) || (b == CH_CR);
            slash_next = has_next && (n == CH_SLASH);
            star_next  = has_next && (n == CH_STAR);
            case (mode)
                M_NORMAL:
                begin
                    if (b == CH_DQUOTE || b == CH_SQUOTE)
                    begin
                        quote_single = (b == CH_SQUOTE);
                        mode         = M_QUOTE;
                        return b;
                    end
                    if (b == CH_SLASH && slash_next)
                    begin
                        mode = M_LINE_OPEN;
                        return CH_SPACE;
                    end
                    if (b == CH_SLASH && star_next)
                    begin
                        mode = M_BLOCK_OPEN;
                        return CH_SPACE;
                    end
                    return b;
                end
                M_QUOTE:
                begin
                    if (b == CH_BSLASH && has_next)
                        mode = M_ESCAPE;
                    else if (b == (quote_single ? CH_SQUOTE : CH_DQUOTE))
                        mode = M_NORMAL;
                    return b;
                end
                M_ESCAPE:
                begin
                    mode = M_QUOTE;
                    return b;
                end
                M_LINE_OPEN:
                begin
                    mode = M_LINE;
                    return CH_SPACE;
                end
                M_LINE:
                begin
                    if (eol)
                    begin
                        mode = M_NORMAL;
                        return b;
                    end
                    return CH_SPACE;
                end
                M_BLOCK_OPEN:
                begin
                    mode = M_BLOCK;
                    return CH_SPACE;
                end
                M_BLOCK:
                begin
                    if (b == CH_STAR && slash_next)
                    begin
                        mode = M_BLOCK_CLOSE;
                        return CH_SPACE;
                    end
                    return eol ? b : CH_SPACE;
                end
                default:
                begin
                    mode = M_NORMAL;
                    return CH_SPACE;
                end
            endcase
        endfunction

        // An accepted input byte releases the held byte and, on last, itself.
        function void take_byte(logic [7:0] in_ch, logic in_last);
            result_t r;
            if (held)
            begin
                r.ch   = blank_byte(held_ch, 1'b1, in_ch);
                r.last = 1'b0;
                expected_text.push_back(r);
            end
            if (in_last)
            begin
                r.ch   = blank_byte(in_ch, 1'b0, 8'h00);
                r.last = 1'b1;
                expected_text.push_back(r);
                mode         = M_NORMAL;
                quote_single = 1'b0;
                held         = 1'b0;
                held_ch      = 8'h00;
            end
            else
            begin
                held_ch = in_ch;
                held    = 1'b1;
            end
        endfunction

        function void check_output(logic [7:0] got_ch, logic got_last);
            result_t want;
            if (expected_text.size() == 0)
            begin
                $error("unexpected output item: out_ch=%02h out_last=%0b", got_ch, got_last);
                failures++;
                return;
            end
            want = expected_text.pop_front();
            if (got_ch !== want.ch)
            begin
                $error("out_ch mismatch: expected %02h, actual %02h", want.ch, got_ch);
                failures++;
            end
            if (got_last !== want.last)
            begin
                $error("out_last mismatch: expected %0b, actual %0b", want.last, got_last);
                failures++;
            end
        endfunction
    endclass

endpackage

/* tb/source_comment_stripper_tb.sv */
module source_comment_stripper_tb;

    timeunit 1ns;
    timeprecision 1ps;

    import scs_pkg::*;
    import stripper_tb_pkg::*;

    // The receiver hold-off fills the three-slot queue; idle limit is a few times
    // the worst quiet stretch (hold-off plus sender gap).
    localparam int HOLD_CYCLES   = 300;
    localparam int IDLE_LIMIT    = 2000;
    localparam int DRAIN_CYCLES  = 8;
    localparam int RANDOM_ITEMS  = 1600;

    typedef enum int {RX_FULL, RX_LIGHT, RX_HALF, RX_PATTERN} rx_style_e;
    typedef enum int {TOK_WORD, TOK_LINE, TOK_BLOCK, TOK_QUOTE, TOK_NOISE} token_e;

    logic       clk       = 1'b0;
    logic       rst_n;
    logic       in_valid  = 1'b0;
    logic       in_ready;
    logic [7:0] ch        = 8'h00;
    logic       last      = 1'b0;
    logic       out_valid;
    logic       out_ready = 1'b0;
    logic [7:0] out_ch;
    logic       out_last;

    strip_scoreboard sb = new();

    logic [7:0] text_buf[$];
    int         burst_left = 0;
    int         items_sent = 0;
    int         idle_cycles = 0;

    source_comment_stripper u_dut (
        .clk       (clk),
        .rst_n     (rst_n),
        .in_valid  (in_valid),
        .in_ready  (in_ready),
        .ch        (ch),
        .last      (last),
        .out_valid (out_valid),
        .out_ready (out_ready),
        .out_ch    (out_ch),
        .out_last  (out_last)
    );

    initial
    begin
        forever #4 clk = ~clk;
    end

    // Present one item and hold it until the handshake; the sender works in
    // bursts with random idle gaps between them.
    task automatic send_byte(input logic [7:0] b, input logic l);
        int gap;
        if (burst_left == 0)
        begin
            gap = $urandom_range(0, 12);
            if (gap != 0)
            begin
                in_valid <= 1'b0;
                repeat (gap) @(posedge clk);
            end
            burst_left = $urandom_range(1, 48);
        end
        burst_left--;
        in_valid <= 1'b1;
        ch       <= b;
        last     <= l;
        @(posedge clk);
        while (!in_ready)
            @(posedge clk);
        items_sent++;
    endtask

    // Whole text from text_buf, last flag on the final byte.
    task automatic send_text();
        for (int i = 0; i < text_buf.size(); i++)
            send_byte(text_buf[i], i == text_buf.size() - 1);
    endtask

    task automatic load_string(input string s);
        text_buf.delete();
        for (int i = 0; i < s.len(); i++)
            text_buf.push_back(s[i]);
    endtask

    // Comment/quote bodies: lean on the bytes that steer the mode.
    function automatic logic [7:0] body_byte();
        int pick;
        pick = $urandom_range(0, 99);
        if (pick < 10)
            return CH_SLASH;
        else if (pick < 20)
            return CH_STAR;
        else if (pick < 25)
            return CH_DQUOTE;
        else if (pick < 30)
            return CH_SQUOTE;
        else if (pick < 36)
            return CH_BSLASH;
        else if (pick < 41)
            return CH_LF;
        else if (pick < 45)
            return CH_CR;
        else if (pick == 45)
            return 8'h00;
        return 8'($urandom_range(1, 255));
    endfunction

    // Mostly well-formed tokens with random content; some texts are cut short
    // so comments and quotes end unclosed.
    task automatic build_random_text();
        int         tokens;
        int         n;
        int         cut;
        token_e     kind;
        logic [7:0] q;
        text_buf.delete();
        tokens = $urandom_range(1, 8);
        repeat (tokens)
        begin
            kind = token_e'($urandom_range(0, 4));
            n    = $urandom_range(0, 8);
            case (kind)
                TOK_WORD:
                begin
                    repeat (n + 1)
                        text_buf.push_back(8'($urandom_range(8'h20, 8'h7E)));
                end
                TOK_LINE:
                begin
                    text_buf.push_back(CH_SLASH);
                    text_buf.push_back(CH_SLASH);
                    repeat (n)
                        text_buf.push_back(body_byte());
                    text_buf.push_back($urandom_range(0, 1) ? CH_LF : CH_CR);
                end
                TOK_BLOCK:
                begin
                    text_buf.push_back(CH_SLASH);
                    text_buf.push_back(CH_STAR);
                    repeat (n)
                        text_buf.push_back(body_byte());
                    text_buf.push_back(CH_STAR);
                    text_buf.push_back(CH_SLASH);
                end
                TOK_QUOTE:
                begin
                    q = $urandom_range(0, 1) ? CH_DQUOTE : CH_SQUOTE;
                    text_buf.push_back(q);
                    repeat (n)
                    begin
                        if ($urandom_range(0, 4) == 0)
                            text_buf.push_back(CH_BSLASH);
                        text_buf.push_back(body_byte());
                    end
                    text_buf.push_back(q);
                end
                default:
                begin
                    repeat ((n % 4) + 1)
                        text_buf.push_back(body_byte());
                end
            endcase
        end
        if ($urandom_range(0, 99) < 15 && text_buf.size() > 1)
        begin
            cut = $urandom_range(1, text_buf.size());
            while (text_buf.size() > cut)
                void'(text_buf.pop_back());
        end
    endtask

    // Receiver: segments of different stall styles, plus two long hold-offs
    // while the sender keeps offering, so in_ready has to drop.
    initial
    begin
        int        seg;
        int        len;
        rx_style_e style;
        seg = 0;
        wait (rst_n);
        @(posedge clk);
        forever
        begin
            if (seg == 3 || seg == 30)
            begin
                out_ready <= 1'b0;
                repeat (HOLD_CYCLES) @(posedge clk);
            end
            len   = $urandom_range(10, 120);
            style = rx_style_e'($urandom_range(0, 3));
            for (int i = 0; i < len; i++)
            begin
                case (style)
                    RX_FULL:    out_ready <= 1'b1;
                    RX_LIGHT:   out_ready <= ($urandom_range(0, 3) != 0);
                    RX_HALF:    out_ready <= 1'($urandom_range(0, 1));
                    default:    out_ready <= ((i % 4) != 3);
                endcase
                @(posedge clk);
            end
            seg++;
        end
    end

    // Monitor: both handshakes sampled at the edge, before any update lands.
    // Also the watchdog on cycles where no item moves.
    always @(posedge clk)
    begin
        if (rst_n)
        begin
            if (in_valid && in_ready)
                sb.take_byte(ch, last);
            if (out_valid && out_ready)
                sb.check_output(out_ch, out_last);
            if ((in_valid && in_ready) || (out_valid && out_ready))
                idle_cycles = 0;
            else
                idle_cycles++;
            if (idle_cycles >= IDLE_LIMIT)
            begin
                $display("source_comment_stripper verification failed");
                $finish;
            end
        end
    end

    initial
    begin
        // falling edge at time zero so the asynchronous reset takes hold at once
        rst_n <= 1'b0;
        repeat (7) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        // single-byte text: final item with nothing held
        load_string("A");
        send_text();
        // byte extremes incl. zero, slash at end of text opens nothing
        load_string("\001\377?/");
        text_buf[2] = 8'h00;
        send_text();
        // line comment ended by CR, CR kept, text resumes
        load_string("//x\ry");
        send_text();
        // block comment keeps CR inside, delimiters blanked
        load_string("/*\r*/");
        send_text();
        // escaped quote and comment opener protected inside a string
        load_string("\"\\\"/*\"");
        send_text();
        // backslash at end of a quote escapes nothing
        load_string("'\\");
        send_text();
        // star at the very end of a block comment closes nothing
        load_string("/**");
        send_text();

        while (items_sent < RANDOM_ITEMS)
        begin
            build_random_text();
            send_text();
        end
        in_valid <= 1'b0;

        // let the monitor log the final item, then drain
        @(posedge clk);
        while (sb.expected_text.size() != 0)
            @(posedge clk);
        repeat (DRAIN_CYCLES) @(posedge clk);

        if (sb.failures == 0)
            $display("source_comment_stripper verification clean");
        else
            $display("source_comment_stripper verification failed");
        $finish;
    end

endmodule
